@@ design/i2csrb_pkg.sv @@
package i2csrb_pkg;

  localparam int IDX_W  = 8;
  localparam int BYTE_W = 8;

  typedef enum logic [2:0] {
    FUNC_TX_START   = 3'd0,
    FUNC_RX_START   = 3'd1,
    FUNC_BUS_WRITE  = 3'd2,
    FUNC_BUS_READ   = 3'd3,
    FUNC_ACK_FAIL   = 3'd4,
    FUNC_HOST_WRITE = 3'd5,
    FUNC_HOST_READ  = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    RD_NONE      = 2'd0,
    RD_OUT_STORE = 2'd1,
    RD_IN_STORE  = 2'd2
  } rd_sel_t;

  localparam logic NOTIFY_RECEIVED = 1'b0;
  localparam logic NOTIFY_SENT     = 1'b1;

  localparam logic CFG_REG_NOTIFY_ENABLE = 1'b0;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

  typedef struct packed {
    rd_sel_t          rd_sel;
    logic             notify_valid;
    logic             notify_kind;
    logic [IDX_W-1:0] notify_index;
  } result_meta_t;

endpackage

@@ design/i2csrb_ram.sv @@
module i2csrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/i2csrb_store.sv @@
module i2csrb_store #(
  parameter int STORE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  i2csrb_pkg::store_req_t         req,
  output logic [i2csrb_pkg::BYTE_W-1:0]  rdata
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [STORE_DEPTH-1:0]          valid_r;
  logic [STORE_DEPTH-1:0]          valid_nxt;
  logic                            hit_r;
  logic                            hit_nxt;
  logic [i2csrb_pkg::BYTE_W-1:0]   ram_q;

  i2csrb_ram #(
    .WIDTH (i2csrb_pkg::BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.waddr[AW-1:0]),
    .wdata (req.wdata),
    .re    (req.re),
    .raddr (req.raddr[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (req.we) begin
      valid_nxt[req.waddr[AW-1:0]] = 1'b1;
    end
    hit_nxt = hit_r;
    if (req.re) begin
      hit_nxt = valid_r[req.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // An entry never written since reset reads as zero.
  assign rdata = hit_r ? ram_q : '0;

endmodule

@@ design/i2csrb_ctrl.sv @@
module i2csrb_ctrl #(
  parameter int STORE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [2:0]                      func,
  input  logic [i2csrb_pkg::BYTE_W-1:0]   data,
  input  logic [i2csrb_pkg::IDX_W-1:0]    host_index,
  input  logic                            notify_enable,
  output i2csrb_pkg::store_req_t          in_req,
  output i2csrb_pkg::store_req_t          out_req,
  output i2csrb_pkg::result_meta_t        meta
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [AW-1:0] ptr_r;
  logic [AW-1:0] ptr_nxt;
  logic          first_r;
  logic          first_nxt;
  logic          tx_r;
  logic          tx_nxt;

  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] ptr_dec;
  logic [AW-1:0] data_idx;
  logic [AW-1:0] host_idx;

  function automatic logic [i2csrb_pkg::IDX_W-1:0] wrap_idx(
    input logic [i2csrb_pkg::IDX_W-1:0] v
  );
    logic [15:0] t;
    int          k;
    t = {8'd0, v};
    for (k = 7; k >= 0; k--) begin
      if (t >= (16'(STORE_DEPTH) << k)) begin
        t = t - (16'(STORE_DEPTH) << k);
      end
    end
    return t[i2csrb_pkg::IDX_W-1:0];
  endfunction

  assign ptr_inc  = (ptr_r == AW'(STORE_DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  assign ptr_dec  = (ptr_r == '0) ? AW'(STORE_DEPTH - 1) : ptr_r - AW'(1);
  assign data_idx = AW'(wrap_idx(data));
  assign host_idx = AW'(wrap_idx(host_index));

  always_comb begin
    ptr_nxt   = ptr_r;
    first_nxt = first_r;
    tx_nxt    = tx_r;
    in_req    = '0;
    out_req   = '0;
    meta      = '{rd_sel: i2csrb_pkg::RD_NONE, notify_valid: 1'b0,
                  notify_kind: i2csrb_pkg::NOTIFY_RECEIVED, notify_index: '0};
    if (accept) begin
      case (i2csrb_pkg::func_t'(func))
        i2csrb_pkg::FUNC_TX_START: begin
          tx_nxt    = 1'b1;
          first_nxt = 1'b1;
        end
        i2csrb_pkg::FUNC_RX_START: begin
          tx_nxt    = 1'b0;
          first_nxt = 1'b1;
        end
        i2csrb_pkg::FUNC_BUS_WRITE: begin
          if (first_r) begin
            ptr_nxt   = data_idx;
            first_nxt = 1'b0;
          end else begin
            in_req.we         = 1'b1;
            in_req.waddr      = i2csrb_pkg::IDX_W'(ptr_r);
            in_req.wdata      = data;
            ptr_nxt           = ptr_inc;
            meta.notify_valid = notify_enable;
            meta.notify_kind  = i2csrb_pkg::NOTIFY_RECEIVED;
            meta.notify_index = notify_enable ? i2csrb_pkg::IDX_W'(ptr_r) : '0;
          end
        end
        i2csrb_pkg::FUNC_BUS_READ: begin
          out_req.re        = 1'b1;
          out_req.raddr     = i2csrb_pkg::IDX_W'(ptr_r);
          meta.rd_sel       = i2csrb_pkg::RD_OUT_STORE;
          ptr_nxt           = ptr_inc;
          first_nxt         = 1'b0;
          if (!first_r && notify_enable) begin
            meta.notify_valid = 1'b1;
            meta.notify_kind  = i2csrb_pkg::NOTIFY_SENT;
            meta.notify_index = i2csrb_pkg::IDX_W'(ptr_dec);
          end
        end
        i2csrb_pkg::FUNC_ACK_FAIL: begin
          if (tx_r) begin
            ptr_nxt = ptr_dec;
          end
        end
        i2csrb_pkg::FUNC_HOST_WRITE: begin
          out_req.we    = 1'b1;
          out_req.waddr = i2csrb_pkg::IDX_W'(host_idx);
          out_req.wdata = data;
        end
        i2csrb_pkg::FUNC_HOST_READ: begin
          in_req.re   = 1'b1;
          in_req.raddr = i2csrb_pkg::IDX_W'(host_idx);
          meta.rd_sel = i2csrb_pkg::RD_IN_STORE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      first_r <= 1'b1;
      tx_r    <= 1'b0;
    end else begin
      ptr_r   <= ptr_nxt;
      first_r <= first_nxt;
      tx_r    <= tx_nxt;
    end
  end

endmodule

@@ design/i2c_slave_register_block_core.sv @@
// Channel   Direction  Handshake           Payload
// in_       request    in_valid/in_stall   in_func, in_data, in_host_index
// out_      result     out_valid/out_stall out_read_data, out_notify_valid,
//                                          out_notify_kind, out_notify_index
// config    APB write  psel/penable/pready paddr, pwdata, prdata
//
// One request is accepted per cycle while in_stall is low; its result passes through the memory
// read stage, registered at the accepting edge, and then through the output register.
// Reset clears the pointer, the tx flag, the notice enable and the per-entry valid bits
// of both stores at once and sets the first-byte flag; requests are accepted right after reset.
// A stalled result holds the output register; a second result waits in the memory read
// stage, and in_stall is raised only while both are full and out_stall is high.
module i2c_slave_register_block_core #(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_data,
  input  logic [7:0]  in_host_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_notify_valid,
  output logic        out_notify_kind,
  output logic [7:0]  out_notify_index,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                         accept;
  logic                         notify_en_r;
  logic                         notify_en_nxt;
  i2csrb_pkg::store_req_t       in_req;
  i2csrb_pkg::store_req_t       out_req;
  i2csrb_pkg::result_meta_t     meta;
  logic [7:0]                   in_store_q;
  logic [7:0]                   out_store_q;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  i2csrb_pkg::result_meta_t     s1_meta_r;
  logic                         s1_adv;
  logic [7:0]                   s1_read_data;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [7:0]                   out_read_data_r;
  logic                         out_notify_valid_r;
  logic                         out_notify_kind_r;
  logic [7:0]                   out_notify_index_r;

  assign pready   = 1'b1;
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    notify_en_nxt = notify_en_r;
    if (psel && penable && pwrite && pready &&
        (paddr[2] == i2csrb_pkg::CFG_REG_NOTIFY_ENABLE)) begin
      notify_en_nxt = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == i2csrb_pkg::CFG_REG_NOTIFY_ENABLE) ? {31'd0, notify_en_r} : '0;

  i2csrb_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .func          (in_func),
    .data          (in_data),
    .host_index    (in_host_index),
    .notify_enable (notify_en_r),
    .in_req        (in_req),
    .out_req       (out_req),
    .meta          (meta)
  );

  i2csrb_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_in_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (in_req),
    .rdata (in_store_q)
  );

  i2csrb_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_out_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (out_req),
    .rdata (out_store_q)
  );

  always_comb begin
    case (s1_meta_r.rd_sel)
      i2csrb_pkg::RD_OUT_STORE: s1_read_data = out_store_q;
      i2csrb_pkg::RD_IN_STORE:  s1_read_data = in_store_q;
      default:                  s1_read_data = '0;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_en_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      notify_en_r <= notify_en_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta_r <= meta;
    end
    if (s1_adv) begin
      out_read_data_r    <= s1_read_data;
      out_notify_valid_r <= s1_meta_r.notify_valid;
      out_notify_kind_r  <= s1_meta_r.notify_kind;
      out_notify_index_r <= s1_meta_r.notify_index;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_notify_valid = out_notify_valid_r;
  assign out_notify_kind  = out_notify_kind_r;
  assign out_notify_index = out_notify_index_r;

endmodule

@@ test/tb_i2c_slave_register_block_core.sv @@
`timescale 1ns / 100ps

module tb_i2c_slave_register_block_core;

  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       notify_valid;
    logic       notify_kind;
    logic [7:0] notify_index;
  } response_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [7:0]  in_data;
  logic [7:0]  in_host_index;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_notify_valid;
  logic        out_notify_kind;
  logic [7:0]  out_notify_index;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  reg_pointer;
  logic        first_byte_due;
  logic        in_tx_mode;
  logic        notices_on;
  logic [7:0]  bus_written_bytes [256];
  logic [7:0]  host_written_bytes [256];

  response_t   awaited_responses [$];
  int          mismatch_count;
  int          requests_sent;
  int          idle_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_off_req;

  i2c_slave_register_block_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data          (in_data),
    .in_host_index    (in_host_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_notify_valid (out_notify_valid),
    .out_notify_kind  (out_notify_kind),
    .out_notify_index (out_notify_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic response_t compute_response(logic [2:0] f, logic [7:0] d, logic [7:0] h);
    response_t r;
    r = '0;
    case (f)
      i2csrb_pkg::FUNC_TX_START: begin
        in_tx_mode = 1'b1;
        first_byte_due = 1'b1;
      end
      i2csrb_pkg::FUNC_RX_START: begin
        in_tx_mode = 1'b0;
        first_byte_due = 1'b1;
      end
      i2csrb_pkg::FUNC_BUS_WRITE: begin
        if (first_byte_due) begin
          reg_pointer = d;
          first_byte_due = 1'b0;
        end else begin
          bus_written_bytes[reg_pointer] = d;
          r.notify_valid = 1'b1;
          r.notify_kind = i2csrb_pkg::NOTIFY_RECEIVED;
          r.notify_index = reg_pointer;
          reg_pointer = reg_pointer + 8'd1;
        end
      end
      i2csrb_pkg::FUNC_BUS_READ: begin
        r.read_data = host_written_bytes[reg_pointer];
        if (!first_byte_due) begin
          r.notify_valid = 1'b1;
          r.notify_kind = i2csrb_pkg::NOTIFY_SENT;
          r.notify_index = reg_pointer - 8'd1;
        end
        reg_pointer = reg_pointer + 8'd1;
        first_byte_due = 1'b0;
      end
      i2csrb_pkg::FUNC_ACK_FAIL: begin
        if (in_tx_mode) begin
          reg_pointer = reg_pointer - 8'd1;
        end
      end
      i2csrb_pkg::FUNC_HOST_WRITE: begin
        host_written_bytes[h] = d;
      end
      i2csrb_pkg::FUNC_HOST_READ: begin
        r.read_data = bus_written_bytes[h];
      end
      default: begin
      end
    endcase
    if (!notices_on) begin
      r.notify_valid = 1'b0;
      r.notify_kind = 1'b0;
      r.notify_index = '0;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_index();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
  endfunction

  task automatic send_request(input logic [2:0] f, input logic [7:0] d, input logic [7:0] h);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_data <= d;
    in_host_index <= h;
    do @(posedge clk); while (in_stall !== 1'b0);
    awaited_responses.push_back(compute_response(f, d, h));
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_notify_enable(input logic value);
    wait_for_drain();
    repeat (3) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * i2csrb_pkg::CFG_REG_NOTIFY_ENABLE);
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    notices_on = value;
  endtask

  task automatic test_directed();
    write_notify_enable(1'b1);
    send_request(i2csrb_pkg::FUNC_HOST_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_HOST_READ, 8'hFF, 8'hFF);
    send_request(i2csrb_pkg::FUNC_RX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hFF, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hA5, 8'hFF);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_HOST_READ, 8'h00, 8'hFF);
    send_request(i2csrb_pkg::FUNC_HOST_READ, 8'hFF, 8'h00);
    send_request(i2csrb_pkg::FUNC_HOST_WRITE, 8'hFF, 8'hFF);
    send_request(i2csrb_pkg::FUNC_HOST_WRITE, 8'h5A, 8'h00);
    send_request(i2csrb_pkg::FUNC_TX_START, 8'hFF, 8'hFF);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hFF, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'hFF, 8'hFF);
    send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_RX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'hFF, 8'hFF);
    send_request(FUNC_UNUSED, 8'hFF, 8'hFF);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
  endtask

  task automatic test_notify_masked();
    write_notify_enable(1'b0);
    send_request(i2csrb_pkg::FUNC_RX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'h10, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'h3C, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hC3, 8'h00);
    send_request(i2csrb_pkg::FUNC_TX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_READ, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_HOST_READ, 8'h00, 8'h11);
  endtask

  task automatic test_random_traffic();
    int phase;
    int target;
    int len;
    int i;
    for (phase = 0; phase < 3; phase++) begin
      write_notify_enable(phase != 1);
      tx_idle_en = (phase != 1);
      rx_idle_en = (phase != 1);
      target = requests_sent + 580;
      while (requests_sent < target) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
            send_request(i2csrb_pkg::FUNC_RX_START, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_BUS_WRITE, pick_index(), 8'($urandom));
            for (i = 0; i < len; i++) begin
              send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'($urandom), 8'($urandom));
            end
          end
          3, 4, 5: begin
            len = $urandom_range(1, 12);
            send_request(i2csrb_pkg::FUNC_RX_START, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_BUS_WRITE, pick_index(), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_TX_START, 8'($urandom), 8'($urandom));
            for (i = 0; i < len; i++) begin
              send_request(i2csrb_pkg::FUNC_BUS_READ, 8'($urandom), 8'($urandom));
            end
            if ($urandom_range(0, 1) == 1) begin
              send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'($urandom), 8'($urandom));
              send_request(i2csrb_pkg::FUNC_BUS_READ, 8'($urandom), 8'($urandom));
            end
          end
          6, 7: begin
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++) begin
              if ($urandom_range(0, 1) == 0) begin
                send_request(i2csrb_pkg::FUNC_HOST_WRITE, 8'($urandom), pick_index());
              end else begin
                send_request(i2csrb_pkg::FUNC_HOST_READ, 8'($urandom), pick_index());
              end
            end
          end
          8: begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++) begin
              send_request(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
            end
          end
          default: begin
            send_request(i2csrb_pkg::FUNC_TX_START, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_BUS_WRITE, pick_index(), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_BUS_READ, 8'($urandom), 8'($urandom));
            send_request(i2csrb_pkg::FUNC_ACK_FAIL, 8'($urandom), 8'($urandom));
          end
        endcase
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    hold_off_req = 1'b1;
    send_request(i2csrb_pkg::FUNC_RX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hF8, 8'h00);
    for (i = 0; i < 38; i++) begin
      send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'($urandom), 8'($urandom));
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    int i;
    send_request(i2csrb_pkg::FUNC_RX_START, 8'h00, 8'h00);
    send_request(i2csrb_pkg::FUNC_BUS_WRITE, 8'hF8, 8'h00);
    send_request(i2csrb_pkg::FUNC_TX_START, 8'h00, 8'h00);
    for (i = 0; i < 17; i++) begin
      send_request(i2csrb_pkg::FUNC_BUS_READ, 8'($urandom), 8'($urandom));
    end
    wait_for_drain();
    for (i = 0; i < 20; i++) begin
      send_request(i2csrb_pkg::FUNC_HOST_READ, 8'($urandom), 8'(8'hF8 + i));
    end
  endtask

  initial begin
    int wait_n;
    out_stall <= 1'b0;
    forever begin
      do @(posedge clk); while (out_valid !== 1'b1 || !rst_n || out_stall);
      wait_n = rx_idle_en ? $urandom_range(0, 5) : 0;
      if (hold_off_req) begin
        wait_n = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input response_t want, input response_t got);
    if (mismatch_count < REPORT_LIMIT) begin
      $display({"mismatch (%s): expected rd=%02h nv=%0b nk=%0b ni=%02h, ",
                "got rd=%02h nv=%0b nk=%0b ni=%02h"},
               what, want.read_data, want.notify_valid, want.notify_kind, want.notify_index,
               got.read_data, got.notify_valid, got.notify_kind, got.notify_index);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_responses
    response_t want;
    response_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {out_read_data, out_notify_valid, out_notify_kind, out_notify_index};
      if (awaited_responses.size() == 0) begin
        report_mismatch("unexpected response", '0, got);
      end else begin
        want = awaited_responses.pop_front();
        if (got.read_data !== want.read_data || got.notify_valid !== want.notify_valid ||
            got.notify_kind !== want.notify_kind || got.notify_index !== want.notify_index) begin
          report_mismatch("field", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int k;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= i2csrb_pkg::FUNC_TX_START;
    in_data <= '0;
    in_host_index <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatch_count = 0;
    requests_sent = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_off_req = 1'b0;
    reg_pointer = '0;
    first_byte_due = 1'b1;
    in_tx_mode = 1'b0;
    notices_on = 1'b0;
    for (k = 0; k < 256; k++) begin
      bus_written_bytes[k] = '0;
      host_written_bytes[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_notify_masked();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();
    wait_for_drain();
    repeat (8) @(posedge clk);
    mismatch_count += awaited_responses.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/i2csrb_pkg.sv
design/i2csrb_ram.sv
design/i2csrb_store.sv
design/i2csrb_ctrl.sv
design/i2c_slave_register_block_core.sv
test/tb_i2c_slave_register_block_core.sv
